/* rtl/scc_pkg.sv */
// ============================================================================
// scc_pkg - shared types and constants of the shifted coincidence counter
// Field widths, letter bounds, register codes and the queue status record.
// ============================================================================
package scc_pkg;

    localparam int BYTE_W  = 8;
    localparam int SHIFT_W = 5;
    localparam int COUNT_W = 24;
    localparam int CFG_W   = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [BYTE_W-1:0] LOW_LETTER  = 8'h61;
    localparam logic [BYTE_W-1:0] HIGH_LETTER = 8'h7A;

    localparam logic [CFG_W-1:0] MAX_SHIFT_RESET = 5'd16;

    // Word index of each configuration register (byte address / 4).
    typedef enum logic [0:0] {
        REG_MAX_SHIFT = 1'b0
    } reg_index_t;

    // Status of the snapshot queue, seen by both the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    function automatic logic is_lower(input logic [BYTE_W-1:0] c);
        return (c >= LOW_LETTER) && (c <= HIGH_LETTER);
    endfunction

endpackage

/* rtl/scc_if.sv */
// ============================================================================
// scc_if - stream interfaces of the shifted coincidence counter
// Text byte channel and result channel, each with valid/ready handshake.
// ============================================================================
interface scc_text_if;
    logic                        valid;
    logic                        ready;
    logic [scc_pkg::BYTE_W-1:0]  text_byte;
    logic                        is_last;

    modport source (output valid, text_byte, is_last, input ready);
    modport sink   (input valid, text_byte, is_last, output ready);
endinterface

interface scc_result_if;
    logic                        valid;
    logic                        ready;
    logic [scc_pkg::SHIFT_W-1:0] shift;
    logic [scc_pkg::COUNT_W-1:0] match_count;
    logic                        last_result;

    modport source (output valid, shift, match_count, last_result, input ready);
    modport sink   (input valid, shift, match_count, last_result, output ready);
endinterface

/* rtl/shifted_coincidence_counter_top.sv */
// ============================================================================
// shifted_coincidence_counter_top - autocorrelation coincidence counter
// Counts equal lowercase letter pairs at every shift of a byte stream and
// reports one count per shift at the end of each text.
// ============================================================================
// The block takes one text byte per clock cycle when not stalled. Every accepted
// byte is compared with the last MAX_SHIFT bytes in parallel, and the counter
// of each shift whose delayed byte is the same lowercase letter goes up by
// one, saturating at its maximum. The transfer that carries is_last adds its
// own pairs, copies all counts into a two-entry snapshot queue and clears the
// delay line and counters in the same cycle, so the next text can start on
// the very next cycle. From the queue the result side produces max_shift
// results (a value of 0 counts as 1, anything above MAX_SHIFT as MAX_SHIFT),
// one per cycle while the sink takes them, each passing the snapshot queue
// and output register. Text input stalls only when both snapshot slots are
// occupied, which happens when texts are shorter than the number of results
// they produce or when the result sink holds off. The max_shift register sits
// at byte address 0 of the APB port; it is meant to be written only while no
// text is in flight. Shift values wider than the five-bit field and counts
// wider than the 24-bit field are presented truncated.
// ============================================================================
module shifted_coincidence_counter_top #(
    parameter int MAX_SHIFT  = 16,
    parameter int COUNT_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [scc_pkg::PADDR_W-1:0]  paddr,
    input  logic [scc_pkg::PDATA_W-1:0]  pwdata,
    output logic [scc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    scc_text_if.sink                     text,
    scc_result_if.source                 result
);

    localparam int N_W        = $clog2(MAX_SHIFT + 1);
    localparam int IDX_W      = (MAX_SHIFT > 1) ? $clog2(MAX_SHIFT) : 1;
    localparam int SNAP_W     = MAX_SHIFT * COUNT_BITS + N_W;
    localparam int SNAP_DEPTH = 2;

    logic [scc_pkg::CFG_W-1:0] max_shift_reg;
    logic                      reg_hit;
    logic                      cfg_write;
    logic [N_W-1:0]            n_cfg;

    scc_pkg::fifo_stat_t       stat;
    logic                      push;
    logic                      pop;
    logic [SNAP_W-1:0]         snap;
    logic [SNAP_W-1:0]         head;

    // Configuration port: no wait states, the word index picks the register.
    assign pready    = 1'b1;
    assign reg_hit   = (paddr[scc_pkg::PADDR_W-1] == scc_pkg::REG_MAX_SHIFT);
    assign cfg_write = psel && penable && pwrite && pready && reg_hit;
    assign prdata    = reg_hit ? scc_pkg::PDATA_W'(max_shift_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_shift_reg <= scc_pkg::MAX_SHIFT_RESET;
        end
        else if (cfg_write)
        begin
            max_shift_reg <= pwdata[scc_pkg::CFG_W-1:0];
        end
    end

    // Number of results per text, with the register clamped to 1..MAX_SHIFT.
    always_comb
    begin
        if (max_shift_reg == '0)
        begin
            n_cfg = N_W'(1);
        end
        else if (int'(max_shift_reg) > MAX_SHIFT)
        begin
            n_cfg = N_W'(MAX_SHIFT);
        end
        else
        begin
            n_cfg = N_W'(max_shift_reg);
        end
    end

    scc_front #(
        .MAX_SHIFT  (MAX_SHIFT),
        .COUNT_BITS (COUNT_BITS),
        .N_W        (N_W),
        .SNAP_W     (SNAP_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (text.valid),
        .in_ready  (text.ready),
        .text_byte (text.text_byte),
        .is_last   (text.is_last),
        .n_cfg     (n_cfg),
        .stat      (stat),
        .push      (push),
        .snap      (snap)
    );

    scc_snap_fifo #(
        .WIDTH (SNAP_W),
        .DEPTH (SNAP_DEPTH)
    ) u_snap_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (snap),
        .pop     (pop),
        .rd_data (head),
        .stat    (stat)
    );

    scc_back #(
        .MAX_SHIFT  (MAX_SHIFT),
        .COUNT_BITS (COUNT_BITS),
        .N_W        (N_W),
        .IDX_W      (IDX_W),
        .SNAP_W     (SNAP_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .stat        (stat),
        .pop         (pop),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .shift       (result.shift),
        .match_count (result.match_count),
        .last_result (result.last_result)
    );

endmodule

/* rtl/scc_front.sv */
// ============================================================================
// scc_front - delay line and per-shift coincidence counters
// Compares each accepted byte with every delayed byte at once and pushes a
// snapshot of the counts into the queue when the final byte of a text arrives.
// ============================================================================
module scc_front #(
    parameter int MAX_SHIFT  = 16,
    parameter int COUNT_BITS = 24,
    parameter int N_W        = 5,
    parameter int SNAP_W     = 389
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [scc_pkg::BYTE_W-1:0]  text_byte,
    input  logic                        is_last,
    input  logic [N_W-1:0]              n_cfg,
    input  scc_pkg::fifo_stat_t         stat,
    output logic                        push,
    output logic [SNAP_W-1:0]           snap
);

    localparam logic [COUNT_BITS-1:0] LIMIT = {COUNT_BITS{1'b1}};

    logic [scc_pkg::BYTE_W-1:0] hist_reg [MAX_SHIFT];
    logic [COUNT_BITS-1:0]      cnt_reg  [MAX_SHIFT];
    logic [COUNT_BITS-1:0]      cnt_next [MAX_SHIFT];
    logic                       letter;
    logic                       accept;

    assign in_ready = !stat.full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && is_last;
    assign letter   = scc_pkg::is_lower(text_byte);

    always_comb
    begin
        for (int t = 0; t < MAX_SHIFT; t++)
        begin
            if (letter && (hist_reg[t] == text_byte) && (cnt_reg[t] != LIMIT))
            begin
                cnt_next[t] = cnt_reg[t] + COUNT_BITS'(1);
            end
            else
            begin
                cnt_next[t] = cnt_reg[t];
            end
        end
    end

    // The snapshot includes the pairs of the final byte itself.
    always_comb
    begin
        snap = '0;
        for (int t = 0; t < MAX_SHIFT; t++)
        begin
            snap[t*COUNT_BITS +: COUNT_BITS] = cnt_next[t];
        end
        snap[SNAP_W-1 -: N_W] = n_cfg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < MAX_SHIFT; t++)
            begin
                hist_reg[t] <= '0;
                cnt_reg[t]  <= '0;
            end
        end
        else if (accept)
        begin
            if (is_last)
            begin
                for (int t = 0; t < MAX_SHIFT; t++)
                begin
                    hist_reg[t] <= '0;
                    cnt_reg[t]  <= '0;
                end
            end
            else
            begin
                hist_reg[0] <= text_byte;
                for (int t = 1; t < MAX_SHIFT; t++)
                begin
                    hist_reg[t] <= hist_reg[t-1];
                end
                for (int t = 0; t < MAX_SHIFT; t++)
                begin
                    cnt_reg[t] <= cnt_next[t];
                end
            end
        end
    end

endmodule

/* rtl/scc_snap_fifo.sv */
// ============================================================================
// scc_snap_fifo - short queue of count snapshots
// Register-based first-in first-out store between the front and the back.
// ============================================================================
module scc_snap_fifo #(
    parameter int WIDTH = 389,
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 pop,
    output logic [WIDTH-1:0]     rd_data,
    output scc_pkg::fifo_stat_t  stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/scc_back.sv */
// ============================================================================
// scc_back - result sequencer
// Walks the snapshot at the head of the queue one shift per transfer and
// presents each result through an output register.
// ============================================================================
module scc_back #(
    parameter int MAX_SHIFT  = 16,
    parameter int COUNT_BITS = 24,
    parameter int N_W        = 5,
    parameter int IDX_W      = 4,
    parameter int SNAP_W     = 389
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [SNAP_W-1:0]            head,
    input  scc_pkg::fifo_stat_t          stat,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [scc_pkg::SHIFT_W-1:0]  shift,
    output logic [scc_pkg::COUNT_W-1:0]  match_count,
    output logic                         last_result
);

    logic [COUNT_BITS-1:0]       counts [MAX_SHIFT];
    logic [N_W-1:0]              n_head;
    logic [N_W-1:0]              sh;
    logic                        at_end;
    logic                        advance;
    logic                        load;
    logic [IDX_W-1:0]            idx_reg;
    logic                        out_valid_reg;
    logic [scc_pkg::SHIFT_W-1:0] shift_reg;
    logic [scc_pkg::COUNT_W-1:0] count_reg;
    logic                        last_reg;

    always_comb
    begin
        for (int t = 0; t < MAX_SHIFT; t++)
        begin
            counts[t] = head[t*COUNT_BITS +: COUNT_BITS];
        end
    end

    assign n_head  = head[SNAP_W-1 -: N_W];
    assign sh      = N_W'(idx_reg) + N_W'(1);
    assign at_end  = (sh == n_head);
    assign advance = !out_valid_reg || out_ready;
    assign load    = advance && !stat.empty;
    assign pop     = load && at_end;

    assign out_valid   = out_valid_reg;
    assign shift       = shift_reg;
    assign match_count = count_reg;
    assign last_result = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= load;
            if (load)
            begin
                idx_reg <= at_end ? '0 : idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            shift_reg <= scc_pkg::SHIFT_W'(sh);
            count_reg <= scc_pkg::COUNT_W'(counts[idx_reg]);
            last_reg  <= at_end;
        end
    end

endmodule

/* rtl/scc_checker.sv */
// ============================================================================
// scc_checker - port-level checks of the shifted coincidence counter
// Watches the result channel for held transfers, the order of shifts and quiet reset.
// ============================================================================
module scc_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [scc_pkg::SHIFT_W-1:0]  shift,
    input  logic [scc_pkg::COUNT_W-1:0]  match_count,
    input  logic                         last_result
);

    logic [scc_pkg::SHIFT_W-1:0] exp_shift_reg, exp_shift_next;
    logic                        xfer;

    assign xfer = out_valid && out_ready;

    // Shifts of one text run upward from one; the last one restarts the run.
    always_comb
    begin
        exp_shift_next = exp_shift_reg;
        if (xfer)
        begin
            exp_shift_next = last_result ? scc_pkg::SHIFT_W'(1)
                                         : exp_shift_reg + scc_pkg::SHIFT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_shift_reg <= scc_pkg::SHIFT_W'(1);
        end
        else
        begin
            exp_shift_reg <= exp_shift_next;
        end
    end

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped before its transfer");

    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(shift) && $stable(match_count) && $stable(last_result))
        else $error("result payload changed while stalled");

    a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
        xfer |-> (shift == exp_shift_reg))
        else $error("result shift out of sequence");

    a_reset_quiet: assert property (@(posedge clk)
        $past(!rst_n) |-> !out_valid)
        else $error("result valid raised straight out of reset");

endmodule

bind shifted_coincidence_counter_top scc_checker u_scc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .shift       (result.shift),
    .match_count (result.match_count),
    .last_result (result.last_result)
);
